@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion helper macros
// concurrent checks on a clock with an active-low reset, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed: label");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: label");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/srfm_pkg.sv @@
// ---------------------------------------------------------------------------
// srfm_pkg
// types and constants of the spi register frame master
// ---------------------------------------------------------------------------
`default_nettype none

package srfm_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_SPARE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_CMD  = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  localparam int unsigned AddrW    = 11;
  localparam int unsigned CountW   = 3;
  localparam int unsigned WordW    = 32;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  localparam logic [7:0] ChecksumBase = 8'hFF;

  // one item as taken from the input channel
  typedef struct packed {
    op_e                op;
    logic [AddrW-1:0]   reg_address;
    logic [CountW-1:0]  byte_count;
    logic [WordW-1:0]   write_word;
    logic               miso_bit;
  } item_t;

  // one result item from the frame engine
  typedef struct packed {
    logic              select_active;
    logic              mosi_bit;
    logic              clock_pulse;
    logic              frame_done;
    logic              checksum_good;
    logic [WordW-1:0]  read_word;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/spi_register_frame_master.sv @@
// ---------------------------------------------------------------------------
// spi_register_frame_master
// spi master frame engine for metering register access with additive checksum
// ---------------------------------------------------------------------------
// usage:
//   each input transfer carries one command in s_axis_tuser_i: tick, start read
//   or start write. a start opens a frame (chip select on) and moves no bit;
//   every later tick moves one serial bit, msb first: low address byte, command
//   byte, then data bytes and the checksum (sent on writes, received on reads).
//   every input transfer yields exactly one output transfer with the chip
//   select, mosi, clock pulse, checksum status and the last good read word;
//   m_axis_tlast_o marks the tick that ends a frame.
//   the input register loads on the input transfer and the result register
//   loads from it when the item advances; output valid is the result
//   register's valid flag, so each item passes both registers in turn.
//   throughput is one transfer per cycle while the output side is ready.
//   when the receiver stalls, the result register holds and the input register
//   keeps one more item; input tready drops only when both are full.
//   reset returns the frame engine to idle with all status and data cleared
//   and empties both registers.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spi_register_frame_master #(
  parameter int unsigned MAX_BYTES = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // reg_address[10:0], byte_count[13:11], write_word[45:14], miso_bit[46], zero[47]
  input  wire  [47:0] s_axis_tdata_i,
  // op[1:0]
  input  wire  [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // select_active[0], mosi_bit[1], clock_pulse[2], checksum_good[3],
  // read_word[35:4], zero[39:36]
  output logic [39:0] m_axis_tdata_o,
  // frame_done
  output logic        m_axis_tlast_o
);

  logic              in_valid_q, in_valid_d;
  srfm_pkg::item_t   in_item_q;
  logic              out_valid_q, out_valid_d;
  srfm_pkg::result_t out_res_q;
  srfm_pkg::result_t eng_res;
  logic              advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_item_q.op          <= srfm_pkg::op_e'(s_axis_tuser_i);
      in_item_q.reg_address <= s_axis_tdata_i[10:0];
      in_item_q.byte_count  <= s_axis_tdata_i[13:11];
      in_item_q.write_word  <= s_axis_tdata_i[45:14];
      in_item_q.miso_bit    <= s_axis_tdata_i[46];
    end
    if (advance) begin
      out_res_q <= eng_res;
    end
  end

  srfm_engine #(
    .MAX_BYTES(MAX_BYTES)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (eng_res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_res_q.frame_done;
  assign m_axis_tdata_o  = {4'b0000, out_res_q.read_word, out_res_q.checksum_good,
                            out_res_q.clock_pulse, out_res_q.mosi_bit,
                            out_res_q.select_active};

  // a frame can only end on a clocked bit with chip select still on
  `ASSERT_IMPLIES(a_done_in_frame, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tdata_o[0] && m_axis_tdata_o[2])
  // clock pulses and mosi only inside a frame
  `ASSERT_IMPLIES(a_clk_needs_sel, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tdata_o[1] || m_axis_tdata_o[2]), m_axis_tdata_o[0])
  // input side backs off only when both registers are full and the output stalls
  `ASSERT_IMPLIES(a_ready_low_full, clk_i, rst_ni, !s_axis_tready_o, in_valid_q && out_valid_q && !m_axis_tready_i)
  // a transfer into the result register always shows up as output valid
  `ASSERT_NEXT(a_advance_valid, clk_i, rst_ni, advance, m_axis_tvalid_o)

endmodule

`default_nettype wire

@@ hdl/srfm_engine.sv @@
// ---------------------------------------------------------------------------
// srfm_engine
// frame state and per-tick bit logic of the spi register frame master
// ---------------------------------------------------------------------------
`default_nettype none

module srfm_engine #(
  parameter int unsigned MAX_BYTES = 4
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               step_i,
  input  srfm_pkg::item_t   item_i,
  output srfm_pkg::result_t result_o
);

  localparam int unsigned BlW = $clog2(MAX_BYTES + 1);
  localparam int unsigned CountW = srfm_pkg::CountW;
  localparam int unsigned WordW = srfm_pkg::WordW;
  // largest count that the byte_count field can ask for after clamping
  localparam int unsigned CntMax =
    (MAX_BYTES < (2 ** CountW - 1)) ? MAX_BYTES : (2 ** CountW - 1);

  srfm_pkg::phase_e phase_q, phase_d;
  logic             is_write_q, is_write_d;
  logic [BlW-1:0]   bytes_left_q, bytes_left_d;
  logic [2:0]       bit_index_q, bit_index_d;
  logic [7:0]       shift_byte_q, shift_byte_d;
  logic [7:0]       sum_accum_q, sum_accum_d;
  logic [WordW-1:0] tx_data_q, tx_data_d;
  logic [WordW-1:0] rx_data_q, rx_data_d;
  logic [WordW-1:0] good_data_q, good_data_d;
  logic             good_flag_q, good_flag_d;
  logic [7:0]       cmd_byte_q, cmd_byte_d;

  logic              start;
  logic              sending;
  logic [7:0]        shifted;
  logic [CountW-1:0] cnt_clamped;
  logic [7:0]        cmd_new;
  logic [BlW-1:0]    load_count;
  logic [7:0]        load_pos;
  logic [7:0]        load_byte;
  logic [7:0]        load_shift;
  logic [7:0]        load_sum;

  assign start = (phase_q == srfm_pkg::PH_IDLE) &&
                 ((item_i.op == srfm_pkg::OP_READ) || (item_i.op == srfm_pkg::OP_WRITE));
  assign sending = (phase_q != srfm_pkg::PH_BODY) || is_write_q;
  assign shifted = {shift_byte_q[6:0], sending ? 1'b0 : item_i.miso_bit};

  always_comb begin
    if (item_i.byte_count == '0) begin
      cnt_clamped = CountW'(1);
    end else if (32'(item_i.byte_count) > CntMax) begin
      cnt_clamped = CountW'(CntMax);
    end else begin
      cnt_clamped = item_i.byte_count;
    end
  end

  assign cmd_new = {item_i.op == srfm_pkg::OP_WRITE, item_i.reg_address[10:8], 4'b0000};

  // next body byte to send: after the command byte all bytes are left,
  // after a data byte one fewer
  assign load_count = (phase_q == srfm_pkg::PH_CMD) ? bytes_left_q
                                                    : bytes_left_q - BlW'(1);
  assign load_pos = 8'(load_count) - 8'd1;

  always_comb begin
    if (load_pos < 8'd4) begin
      load_byte = tx_data_q[load_pos[1:0]*8 +: 8];
    end else begin
      load_byte = 8'h00;
    end
    if (load_count != '0) begin
      load_shift = load_byte;
      load_sum   = sum_accum_q + load_byte;
    end else begin
      load_shift = srfm_pkg::ChecksumBase - sum_accum_q;
      load_sum   = sum_accum_q;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    is_write_d   = is_write_q;
    bytes_left_d = bytes_left_q;
    bit_index_d  = bit_index_q;
    shift_byte_d = shift_byte_q;
    sum_accum_d  = sum_accum_q;
    tx_data_d    = tx_data_q;
    rx_data_d    = rx_data_q;
    good_data_d  = good_data_q;
    good_flag_d  = good_flag_q;
    cmd_byte_d   = cmd_byte_q;

    result_o.select_active = 1'b0;
    result_o.mosi_bit      = 1'b0;
    result_o.clock_pulse   = 1'b0;
    result_o.frame_done    = 1'b0;

    if (start) begin
      is_write_d   = (item_i.op == srfm_pkg::OP_WRITE);
      cmd_byte_d   = cmd_new;
      bytes_left_d = BlW'(cnt_clamped);
      bit_index_d  = 3'd0;
      shift_byte_d = item_i.reg_address[7:0];
      sum_accum_d  = item_i.reg_address[7:0] + cmd_new;
      tx_data_d    = item_i.write_word;
      rx_data_d    = '0;
      phase_d      = srfm_pkg::PH_ADDR;
      result_o.select_active = 1'b1;
    end else if (phase_q != srfm_pkg::PH_IDLE) begin
      result_o.select_active = 1'b1;
      result_o.clock_pulse   = 1'b1;
      result_o.mosi_bit      = sending & shift_byte_q[7];
      shift_byte_d           = shifted;
      if (bit_index_q != 3'd7) begin
        bit_index_d = bit_index_q + 3'd1;
      end else begin
        bit_index_d = 3'd0;
        unique case (phase_q)
          srfm_pkg::PH_ADDR: begin
            phase_d      = srfm_pkg::PH_CMD;
            shift_byte_d = cmd_byte_q;
          end
          srfm_pkg::PH_CMD: begin
            phase_d = srfm_pkg::PH_BODY;
            if (is_write_q) begin
              shift_byte_d = load_shift;
              sum_accum_d  = load_sum;
            end else begin
              shift_byte_d = 8'h00;
            end
          end
          srfm_pkg::PH_BODY: begin
            if (bytes_left_q != '0) begin
              bytes_left_d = bytes_left_q - BlW'(1);
              if (is_write_q) begin
                shift_byte_d = load_shift;
                sum_accum_d  = load_sum;
              end else begin
                rx_data_d    = {rx_data_q[WordW-9:0], shifted};
                sum_accum_d  = sum_accum_q + shifted;
                shift_byte_d = 8'h00;
              end
            end else begin
              if (!is_write_q) begin
                good_flag_d = (shifted == (srfm_pkg::ChecksumBase - sum_accum_q));
                if (good_flag_d) begin
                  good_data_d = rx_data_q;
                end
              end
              result_o.frame_done = 1'b1;
              phase_d             = srfm_pkg::PH_IDLE;
            end
          end
          default: begin
            phase_d = srfm_pkg::PH_IDLE;
          end
        endcase
      end
    end

    result_o.checksum_good = good_flag_d;
    result_o.read_word     = good_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= srfm_pkg::PH_IDLE;
      is_write_q   <= 1'b0;
      bytes_left_q <= '0;
      bit_index_q  <= 3'd0;
      shift_byte_q <= 8'h00;
      sum_accum_q  <= 8'h00;
      tx_data_q    <= '0;
      rx_data_q    <= '0;
      good_data_q  <= '0;
      good_flag_q  <= 1'b0;
      cmd_byte_q   <= 8'h00;
    end else if (step_i) begin
      phase_q      <= phase_d;
      is_write_q   <= is_write_d;
      bytes_left_q <= bytes_left_d;
      bit_index_q  <= bit_index_d;
      shift_byte_q <= shift_byte_d;
      sum_accum_q  <= sum_accum_d;
      tx_data_q    <= tx_data_d;
      rx_data_q    <= rx_data_d;
      good_data_q  <= good_data_d;
      good_flag_q  <= good_flag_d;
      cmd_byte_q   <= cmd_byte_d;
    end
  end

endmodule

`default_nettype wire
